// File: design/cbpg_pkg.sv
// Shared types, constants and the step table for the cubic Bezier point generator.
// No dependencies; every other design file imports this package.
`default_nettype none

package cbpg_pkg;

    // Default values of the top-level parameters
    localparam int DEF_MAX_SEGMENTS = 63;
    localparam int DEF_COORD_WIDTH  = 16;

    // Fixed widths
    localparam int SEG_W   = 6;   // segment count and point index
    localparam int T_W     = 17;  // t and u, Q0.16 with room for 1.0
    localparam int REM_W   = 6;   // remainder of 65536 / S
    localparam int SQ_W    = 34;  // u*u, u*t, t*t
    localparam int CUBE_W  = 49;  // Q0.48 weight terms, up to 1.0
    localparam int WGT_W   = 25;  // weights rounded to Q0.24, up to 1.0
    localparam int WGT_SH  = 24;  // Q0.48 -> Q0.24 and Q12.28 -> Q12.4
    localparam int NUM_PTS = 8;   // x0,y0,x1,y1,x2,y2,x3,y3

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // Index and last flag that travel beside each curve point
    typedef struct packed {
        logic [SEG_W-1:0] idx;
        logic             last;
    } cbpg_side_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic last;
    } cbpg_gen_status_t;

    typedef logic [3:0][WGT_W-1:0] cbpg_wgt_t;

    // Quotient and remainder of 65536 / S, S = 1..63; packed {quo, rem}
    function automatic logic [T_W+REM_W-1:0] step_div(input logic [SEG_W-1:0] s);
        logic [T_W-1:0]   q;
        logic [REM_W-1:0] r;
        q = '0;
        r = '0;
        case (s)
            6'd1:  begin q = 17'd65536; r = 6'd0;  end
            6'd2:  begin q = 17'd32768; r = 6'd0;  end
            6'd3:  begin q = 17'd21845; r = 6'd1;  end
            6'd4:  begin q = 17'd16384; r = 6'd0;  end
            6'd5:  begin q = 17'd13107; r = 6'd1;  end
            6'd6:  begin q = 17'd10922; r = 6'd4;  end
            6'd7:  begin q = 17'd9362;  r = 6'd2;  end
            6'd8:  begin q = 17'd8192;  r = 6'd0;  end
            6'd9:  begin q = 17'd7281;  r = 6'd7;  end
            6'd10: begin q = 17'd6553;  r = 6'd6;  end
            6'd11: begin q = 17'd5957;  r = 6'd9;  end
            6'd12: begin q = 17'd5461;  r = 6'd4;  end
            6'd13: begin q = 17'd5041;  r = 6'd3;  end
            6'd14: begin q = 17'd4681;  r = 6'd2;  end
            6'd15: begin q = 17'd4369;  r = 6'd1;  end
            6'd16: begin q = 17'd4096;  r = 6'd0;  end
            6'd17: begin q = 17'd3855;  r = 6'd1;  end
            6'd18: begin q = 17'd3640;  r = 6'd16; end
            6'd19: begin q = 17'd3449;  r = 6'd5;  end
            6'd20: begin q = 17'd3276;  r = 6'd16; end
            6'd21: begin q = 17'd3120;  r = 6'd16; end
            6'd22: begin q = 17'd2978;  r = 6'd20; end
            6'd23: begin q = 17'd2849;  r = 6'd9;  end
            6'd24: begin q = 17'd2730;  r = 6'd16; end
            6'd25: begin q = 17'd2621;  r = 6'd11; end
            6'd26: begin q = 17'd2520;  r = 6'd16; end
            6'd27: begin q = 17'd2427;  r = 6'd7;  end
            6'd28: begin q = 17'd2340;  r = 6'd16; end
            6'd29: begin q = 17'd2259;  r = 6'd25; end
            6'd30: begin q = 17'd2184;  r = 6'd16; end
            6'd31: begin q = 17'd2114;  r = 6'd2;  end
            6'd32: begin q = 17'd2048;  r = 6'd0;  end
            6'd33: begin q = 17'd1985;  r = 6'd31; end
            6'd34: begin q = 17'd1927;  r = 6'd18; end
            6'd35: begin q = 17'd1872;  r = 6'd16; end
            6'd36: begin q = 17'd1820;  r = 6'd16; end
            6'd37: begin q = 17'd1771;  r = 6'd9;  end
            6'd38: begin q = 17'd1724;  r = 6'd24; end
            6'd39: begin q = 17'd1680;  r = 6'd16; end
            6'd40: begin q = 17'd1638;  r = 6'd16; end
            6'd41: begin q = 17'd1598;  r = 6'd18; end
            6'd42: begin q = 17'd1560;  r = 6'd16; end
            6'd43: begin q = 17'd1524;  r = 6'd4;  end
            6'd44: begin q = 17'd1489;  r = 6'd20; end
            6'd45: begin q = 17'd1456;  r = 6'd16; end
            6'd46: begin q = 17'd1424;  r = 6'd32; end
            6'd47: begin q = 17'd1394;  r = 6'd18; end
            6'd48: begin q = 17'd1365;  r = 6'd16; end
            6'd49: begin q = 17'd1337;  r = 6'd23; end
            6'd50: begin q = 17'd1310;  r = 6'd36; end
            6'd51: begin q = 17'd1285;  r = 6'd1;  end
            6'd52: begin q = 17'd1260;  r = 6'd16; end
            6'd53: begin q = 17'd1236;  r = 6'd28; end
            6'd54: begin q = 17'd1213;  r = 6'd34; end
            6'd55: begin q = 17'd1191;  r = 6'd31; end
            6'd56: begin q = 17'd1170;  r = 6'd16; end
            6'd57: begin q = 17'd1149;  r = 6'd43; end
            6'd58: begin q = 17'd1129;  r = 6'd54; end
            6'd59: begin q = 17'd1110;  r = 6'd46; end
            6'd60: begin q = 17'd1092;  r = 6'd16; end
            6'd61: begin q = 17'd1074;  r = 6'd22; end
            6'd62: begin q = 17'd1057;  r = 6'd2;  end
            6'd63: begin q = 17'd1040;  r = 6'd16; end
            default: begin q = '0; r = '0; end
        endcase
        return {q, r};
    endfunction

endpackage

`default_nettype wire

// File: design/cbpg_param_gen.sv
// Run sequencer: takes one curve word, then issues t_i = round(i/S) for i = 0..S.
// Depends on cbpg_pkg (step table, side and status types).
`default_nettype none

module cbpg_param_gen #(
    parameter int MAX_SEGMENTS = cbpg_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_WIDTH  = cbpg_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                                           aclk,
    input  wire logic                                           aresetn,
    input  wire logic                                           adv,
    input  wire logic                                           in_valid,
    output logic                                                in_ready,
    input  wire logic [cbpg_pkg::NUM_PTS*COORD_WIDTH-1:0]       in_pts,
    input  wire logic [cbpg_pkg::SEG_W-1:0]                     in_seg,
    output logic                                                out_valid,
    output logic [cbpg_pkg::T_W-1:0]                            out_t,
    output cbpg_pkg::cbpg_side_t                                out_side,
    output logic [cbpg_pkg::NUM_PTS*COORD_WIDTH-1:0]            out_pts,
    output cbpg_pkg::cbpg_gen_status_t                          status
);
    import cbpg_pkg::*;

    localparam logic [SEG_W-1:0] MAX_SEG = SEG_W'(MAX_SEGMENTS);

    logic                          busy_reg,     busy_next;
    logic                          last_reg,     last_next;
    logic [SEG_W-1:0]              idx_reg,      idx_next;
    logic [SEG_W-1:0]              seg_reg,      seg_next;
    logic [T_W-1:0]                t_reg,        t_next;
    logic [REM_W-1:0]              rem_reg,      rem_next;
    logic [T_W-1:0]                quo_reg,      quo_next;
    logic [REM_W-1:0]              srem_reg,     srem_next;
    logic [NUM_PTS*COORD_WIDTH-1:0] pts_reg,     pts_next;

    logic                          accept;
    logic [SEG_W-1:0]              seg_eff;
    logic [T_W+REM_W-1:0]          div_word;
    logic [REM_W:0]                rem_sum;
    logic                          carry;

    // New run may start while the last point of the current one is issued
    assign in_ready = adv && (!busy_reg || last_reg);
    assign accept   = in_valid && in_ready;
    assign seg_eff  = (in_seg > MAX_SEG) ? MAX_SEG : in_seg;
    assign div_word = step_div(seg_eff);

    // Remainder walk: numerator grows by 65536 per point, one correction at most
    assign rem_sum = {1'b0, rem_reg} + {1'b0, srem_reg};
    assign carry   = (rem_sum >= {1'b0, seg_reg});

    always_comb begin
        busy_next = busy_reg;
        last_next = last_reg;
        idx_next  = idx_reg;
        seg_next  = seg_reg;
        t_next    = t_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        srem_next = srem_reg;
        pts_next  = pts_reg;
        if (accept) begin
            busy_next = 1'b1;
            last_next = (seg_eff == '0);
            idx_next  = '0;
            seg_next  = seg_eff;
            t_next    = '0;
            rem_next  = seg_eff >> 1;
            quo_next  = div_word[T_W+REM_W-1:REM_W];
            srem_next = div_word[REM_W-1:0];
            pts_next  = in_pts;
        end else if (adv && busy_reg) begin
            if (last_reg) begin
                busy_next = 1'b0;
            end else begin
                idx_next  = idx_reg + 1'b1;
                last_next = ((idx_reg + 1'b1) == seg_reg);
                t_next    = t_reg + quo_reg + T_W'(carry);
                rem_next  = carry ? REM_W'(rem_sum - {1'b0, seg_reg}) : REM_W'(rem_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        last_reg <= last_next;
        idx_reg  <= idx_next;
        seg_reg  <= seg_next;
        t_reg    <= t_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        srem_reg <= srem_next;
        pts_reg  <= pts_next;
    end

    assign out_valid     = busy_reg;
    assign out_t         = t_reg;
    assign out_side.idx  = idx_reg;
    assign out_side.last = last_reg;
    assign out_pts       = pts_reg;
    assign status.busy   = busy_reg;
    assign status.last   = last_reg;

endmodule

`default_nettype wire

// File: design/cbpg_weight_pipe.sv
// Three-stage Bernstein weight pipeline: t -> u^3, 3u^2t, 3ut^2, t^3 in Q0.24.
// Depends on cbpg_pkg (widths, side and weight types).
`default_nettype none

module cbpg_weight_pipe #(
    parameter int COORD_WIDTH = cbpg_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       adv,
    input  wire logic                                       in_valid,
    input  wire logic [cbpg_pkg::T_W-1:0]                   in_t,
    input  wire cbpg_pkg::cbpg_side_t                       in_side,
    input  wire logic [cbpg_pkg::NUM_PTS*COORD_WIDTH-1:0]   in_pts,
    output logic                                            out_valid,
    output cbpg_pkg::cbpg_wgt_t                             out_wgt,
    output cbpg_pkg::cbpg_side_t                            out_side,
    output logic [cbpg_pkg::NUM_PTS*COORD_WIDTH-1:0]        out_pts
);
    import cbpg_pkg::*;

    localparam int MUL_W = SQ_W + T_W;
    localparam int RND_W = CUBE_W + 1;
    localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (WGT_SH - 1);

    logic [2:0]                     vld_reg;
    cbpg_side_t                     side_reg [3];
    logic [NUM_PTS*COORD_WIDTH-1:0] pts_reg  [3];

    // stage 1
    logic [T_W-1:0]  u1_next;
    logic [T_W-1:0]  u1_reg, t1_reg;
    logic [SQ_W-1:0] uu_reg, tt_reg;
    // stage 2
    logic [MUL_W-1:0]   m0_full, m1_full, m2_full, m3_full;
    logic [CUBE_W-1:0]  m_reg [4];
    // stage 3
    logic [RND_W-1:0]   tri_next [4];
    cbpg_wgt_t          wgt_reg;

    assign u1_next = T_ONE - in_t;

    // Squares of u and t
    always_ff @(posedge aclk) begin
        if (adv) begin
            u1_reg      <= u1_next;
            t1_reg      <= in_t;
            uu_reg      <= u1_next * u1_next;
            tt_reg      <= in_t * in_t;
            side_reg[0] <= in_side;
            pts_reg[0]  <= in_pts;
        end
    end

    // Cubic terms, exact Q0.48
    assign m0_full = uu_reg * u1_reg;
    assign m1_full = uu_reg * t1_reg;
    assign m2_full = tt_reg * u1_reg;
    assign m3_full = tt_reg * t1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg[0]    <= m0_full[CUBE_W-1:0];
            m_reg[1]    <= m1_full[CUBE_W-1:0];
            m_reg[2]    <= m2_full[CUBE_W-1:0];
            m_reg[3]    <= m3_full[CUBE_W-1:0];
            side_reg[1] <= side_reg[0];
            pts_reg[1]  <= pts_reg[0];
        end
    end

    // Times three for the middle terms, then round to Q0.24
    always_comb begin
        tri_next[0] = {1'b0, m_reg[0]};
        tri_next[1] = {m_reg[1], 1'b0} + {1'b0, m_reg[1]};
        tri_next[2] = {m_reg[2], 1'b0} + {1'b0, m_reg[2]};
        tri_next[3] = {1'b0, m_reg[3]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                wgt_reg[k] <= WGT_W'((tri_next[k] + HALF_LSB) >> WGT_SH);
            end
            side_reg[2] <= side_reg[1];
            pts_reg[2]  <= pts_reg[1];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign out_wgt   = wgt_reg;
    assign out_side  = side_reg[2];
    assign out_pts   = pts_reg[2];

endmodule

`default_nettype wire

// File: design/cbpg_blend_pipe.sv
// Blend pipeline: weighted sums of the control points, rounding, saturation, output word.
// Depends on cbpg_pkg (widths, side and weight types).
`default_nettype none

module cbpg_blend_pipe #(
    parameter int COORD_WIDTH = cbpg_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       adv,
    input  wire logic                                       in_valid,
    input  wire cbpg_pkg::cbpg_wgt_t                        in_wgt,
    input  wire cbpg_pkg::cbpg_side_t                       in_side,
    input  wire logic [cbpg_pkg::NUM_PTS*COORD_WIDTH-1:0]   in_pts,
    output logic                                            out_valid,
    output logic signed [COORD_WIDTH-1:0]                   out_x,
    output logic signed [COORD_WIDTH-1:0]                   out_y,
    output cbpg_pkg::cbpg_side_t                            out_side
);
    import cbpg_pkg::*;

    localparam int PROD_W = WGT_W + 1 + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - WGT_SH;
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (WGT_SH - 1);
    localparam logic signed [RND_W-1:0] SAT_HI = {5'b00000, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO = {5'b11111, {(COORD_WIDTH-1){1'b0}}};

    logic [2:0]                  vld_reg;
    cbpg_side_t                  side_reg [3];
    logic signed [PROD_W-1:0]    px_reg [4];
    logic signed [PROD_W-1:0]    py_reg [4];
    logic signed [SUM_W-1:0]     sx_next, sy_next;
    logic signed [RND_W-1:0]     rx_reg, ry_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;

    // Weight times coordinate, x and y in parallel
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                px_reg[k] <= $signed({1'b0, in_wgt[k]}) *
                             $signed(in_pts[(2*k)*COORD_WIDTH +: COORD_WIDTH]);
                py_reg[k] <= $signed({1'b0, in_wgt[k]}) *
                             $signed(in_pts[(2*k+1)*COORD_WIDTH +: COORD_WIDTH]);
            end
            side_reg[0] <= in_side;
        end
    end

    // Sum of four, round half up back to Q12.4 (floor of biased value)
    always_comb begin
        sx_next = SUM_W'(px_reg[0]) + SUM_W'(px_reg[1]) + SUM_W'(px_reg[2])
                + SUM_W'(px_reg[3]) + HALF_LSB;
        sy_next = SUM_W'(py_reg[0]) + SUM_W'(py_reg[1]) + SUM_W'(py_reg[2])
                + SUM_W'(py_reg[3]) + HALF_LSB;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg      <= sx_next[SUM_W-1:WGT_SH];
            ry_reg      <= sy_next[SUM_W-1:WGT_SH];
            side_reg[1] <= side_reg[0];
        end
    end

    // Saturate into the output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (rx_reg > SAT_HI) begin
                x_reg <= SAT_HI[COORD_WIDTH-1:0];
            end else if (rx_reg < SAT_LO) begin
                x_reg <= SAT_LO[COORD_WIDTH-1:0];
            end else begin
                x_reg <= rx_reg[COORD_WIDTH-1:0];
            end
            if (ry_reg > SAT_HI) begin
                y_reg <= SAT_HI[COORD_WIDTH-1:0];
            end else if (ry_reg < SAT_LO) begin
                y_reg <= SAT_LO[COORD_WIDTH-1:0];
            end else begin
                y_reg <= ry_reg[COORD_WIDTH-1:0];
            end
            side_reg[2] <= side_reg[1];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg[2];

endmodule

`default_nettype wire

// File: design/cubic_bezier_point_generator.sv
// Cubic Bezier point generator: top level, stream ports and pipeline stall control.
// Depends on cbpg_pkg, cbpg_param_gen, cbpg_weight_pipe and cbpg_blend_pipe.
//
// Usage:
//   Slave side takes one word per curve: four control points (signed Q12.4)
//   and a segment count S (above MAX_SEGMENTS it is clipped). Master side
//   returns S+1 words, the curve points at t = i/S for i = 0..S, with the
//   index i and tlast on the final point; S = 0 returns P0 alone.
//   Throughput: one result word per cycle while the output is not stalled;
//   a new curve word is taken in the cycle the last point of the current run
//   enters the pipeline. The sequencer issues one t per cycle unless stalled.
//   Path: after its curve word is accepted, the first point passes the
//   sequencer, three weight stages, product, sum/round, saturate/output.
//   Reset clears the sequencer and every valid bit; nothing is in flight.
//   Backpressure: while m_tvalid is high and m_tready low, the whole
//   pipeline and the sequencer hold; s_tready drops; no point is lost.
`default_nettype none

module cubic_bezier_point_generator #(
    parameter int MAX_SEGMENTS = cbpg_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_WIDTH  = cbpg_pkg::DEF_COORD_WIDTH,
    localparam int IN_W  = ((8*COORD_WIDTH + cbpg_pkg::SEG_W + 7) / 8) * 8,
    localparam int OUT_W = ((2*COORD_WIDTH + cbpg_pkg::SEG_W + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, segment_count, zero pad
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // curve_x, curve_y, point_index, zero pad
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic                  m_tlast
);
    import cbpg_pkg::*;

    localparam int PTS_W = NUM_PTS * COORD_WIDTH;

    logic                           adv;
    logic                           g_valid;
    logic [T_W-1:0]                 g_t;
    cbpg_side_t                     g_side;
    logic [PTS_W-1:0]               g_pts;
    cbpg_gen_status_t               g_status;
    logic                           w_valid;
    cbpg_wgt_t                      w_wgt;
    cbpg_side_t                     w_side;
    logic [PTS_W-1:0]               w_pts;
    logic signed [COORD_WIDTH-1:0]  b_x, b_y;
    cbpg_side_t                     b_side;

    // Whole pipeline moves unless the output word is stalled
    assign adv = !m_tvalid || m_tready;

    cbpg_param_gen #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pts    (s_tdata[PTS_W-1:0]),
        .in_seg    (s_tdata[PTS_W +: SEG_W]),
        .out_valid (g_valid),
        .out_t     (g_t),
        .out_side  (g_side),
        .out_pts   (g_pts),
        .status    (g_status)
    );

    cbpg_weight_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_wgt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (g_valid),
        .in_t      (g_t),
        .in_side   (g_side),
        .in_pts    (g_pts),
        .out_valid (w_valid),
        .out_wgt   (w_wgt),
        .out_side  (w_side),
        .out_pts   (w_pts)
    );

    cbpg_blend_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (w_valid),
        .in_wgt    (w_wgt),
        .in_side   (w_side),
        .in_pts    (w_pts),
        .out_valid (m_tvalid),
        .out_x     (b_x),
        .out_y     (b_y),
        .out_side  (b_side)
    );

    // Output word
    assign m_tdata = OUT_W'({b_side.idx, b_y, b_x});
    assign m_tlast = b_side.last;

    // A curve word is only taken when the sequencer is free or on its last point
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!g_status.busy || g_status.last))
        else $error("curve word accepted in the middle of a run");

    // No input taken while the output word is stalled
    a_no_take_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input ready while output stalled");

    // Point index never passes MAX_SEGMENTS, the clip limit of the segment count
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (b_side.idx <= SEG_W'(MAX_SEGMENTS)))
        else $error("point index beyond segment limit");

    // A run starting point carries index zero: after a last point comes index 0
    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (g_valid && adv && g_side.last) |=> (!g_valid || (g_side.idx == '0)))
        else $error("run did not restart at index zero");

endmodule

`default_nettype wire
